// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the occupancy array engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clk edge, skipped while rst is high.
`define OAE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed in occupancy array engine");
// Check a property on every rising clk edge, reset cycles included.
`define OAE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed in occupancy array engine");
`else
`define OAE_ASSERT(lbl, prop)
`define OAE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/core/oae_pkg.sv =====
// Package of the occupancy array engine: default depth, widths, request and status codes, states.
`default_nettype none
package oae_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 8;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 3;

  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SWAP    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MINMAX  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SORT    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_OCCUPIED  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ZERO_SWAP = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ONE,
    ST_RD_A,
    ST_RD_B,
    ST_WR_X,
    ST_WR_Y,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/oae_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module oae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/occupancy_array_engine_unit.sv =====
// Top level of the occupancy array engine: request sequencer around one word RAM.
`default_nettype none
`include "assert_macros.svh"
//
// Channel   Direction  Transfer when       Payload
// request   in         start && !busy      req_type, value, pos_a, pos_b
// result    out        done (one cycle)    status, max_value, min_value, read_value
//
// Add, delete and read read one word, then write or report it; swap reads both words, then
//   writes both (neither when a slot holds zero); a position out of range or an unknown
//   request goes straight to the response; minmax scans every word; reverse exchanges each
//   mirrored pair; sort scans from each position to the last for the minimum and moves it
//   there. The word RAM has a single read port: every scan step reads one word.
// Reset (rst, synchronous) clears the sequencer and one valid bit per entry; an entry not
//   yet written reads as zero, so no clearing pass runs and a request is taken right after.
// busy is high from the accepting edge through the done cycle; results cannot be stalled.
//
module occupancy_array_engine_unit #(
  parameter int DEPTH = oae_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [oae_pkg::REQ_W-1:0]    req_type,
  input  wire logic signed [oae_pkg::WORD_W-1:0]   value,
  input  wire logic        [oae_pkg::POS_W-1:0]    pos_a,
  input  wire logic        [oae_pkg::POS_W-1:0]    pos_b,
  output logic                                     done,
  output logic             [oae_pkg::STAT_W-1:0]   status,
  output logic signed      [oae_pkg::WORD_W-1:0]   max_value,
  output logic signed      [oae_pkg::WORD_W-1:0]   min_value,
  output logic signed      [oae_pkg::WORD_W-1:0]   read_value
);
  import oae_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW-1:0] SORT_END = AW'(DEPTH - 2);

  state_t state, state_next;

  // Latched request
  logic        [REQ_W-1:0]  req;
  logic signed [WORD_W-1:0] val;
  logic        [POS_W-1:0]  pa;
  logic        [POS_W-1:0]  pb;

  // Pair addresses and data for swap, reverse and the sort exchange
  logic        [AW-1:0]     xa;
  logic        [AW-1:0]     xb;
  logic signed [WORD_W-1:0] da;
  logic signed [WORD_W-1:0] db;

  // Scan pipeline: issue counter, start index, and the stage that sees read data
  logic        [AW-1:0]     scnt;
  logic        [AW-1:0]     sstart;
  logic                     pipe_vld;
  logic                     pipe_first;
  logic        [AW-1:0]     pipe_idx;

  // Scan results
  logic signed [WORD_W-1:0] mx;
  logic signed [WORD_W-1:0] mn;
  logic        [AW-1:0]     sel;
  logic signed [WORD_W-1:0] selval;
  logic signed [WORD_W-1:0] ival;

  // Result registers
  logic        [STAT_W-1:0] res_status;
  logic signed [WORD_W-1:0] res_max;
  logic signed [WORD_W-1:0] res_min;
  logic signed [WORD_W-1:0] res_read;

  // RAM port and occupancy of written entries
  logic                     wr_en;
  logic        [AW-1:0]     wr_addr;
  logic signed [WORD_W-1:0] wr_data;
  logic        [AW-1:0]     rd_addr;
  logic        [WORD_W-1:0] rdata;
  logic        [DEPTH-1:0]  valid;
  logic                     vld_q;
  logic signed [WORD_W-1:0] eff;

  logic                     a_ok;
  logic                     b_ok;
  logic        [AW-1:0]     pa_idx;
  logic        [AW-1:0]     pb_idx;
  logic                     eff_pos;
  logic                     swap_zero;
  logic                     rev_more;

  oae_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // A never-written entry reads as zero
  assign eff       = vld_q ? $signed(rdata) : '0;
  assign a_ok      = (pa != '0) && (pa <= POS_W'(DEPTH));
  assign b_ok      = (pb != '0) && (pb <= POS_W'(DEPTH));
  assign pa_idx    = AW'(pa - POS_W'(1));
  assign pb_idx    = AW'(pb - POS_W'(1));
  assign eff_pos   = (eff != '0) && !eff[WORD_W-1];
  assign swap_zero = (da == '0) || (eff == '0);
  // Another pair remains while the advanced left index stays below the advanced right one
  assign rev_more  = ({1'b0, xa} + (AW+1)'(2)) < {1'b0, xb};

  assign busy       = (state != ST_IDLE);
  assign done       = (state == ST_RESP);
  assign status     = res_status;
  assign max_value  = res_max;
  assign min_value  = res_min;
  assign read_value = res_read;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        case (req)
          REQ_ADD, REQ_DELETE, REQ_READ: state_next = a_ok ? ST_ONE : ST_RESP;
          REQ_SWAP:                      state_next = (a_ok && b_ok) ? ST_RD_A : ST_RESP;
          REQ_MINMAX, REQ_SORT:          state_next = ST_SCAN;
          REQ_REVERSE:                   state_next = ST_RD_A;
          default:                       state_next = ST_RESP;
        endcase
      end
      ST_ONE:  state_next = ST_RESP;
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_WR_X;
      ST_WR_X: begin
        state_next = (req == REQ_SWAP && swap_zero) ? ST_RESP : ST_WR_Y;
      end
      ST_WR_Y: begin
        if (req == REQ_REVERSE && rev_more) begin
          state_next = ST_RD_A;
        end else if (req == REQ_SORT && sstart != SORT_END) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_SCAN:   state_next = (scnt == LAST_IDX) ? ST_DRAIN : ST_SCAN;
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = (req == REQ_SORT) ? ST_WR_X : ST_RESP;
      ST_RESP:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // RAM control per state
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = xa;
    wr_data = eff;
    case (state)
      ST_CHECK: rd_addr = pa_idx;
      ST_ONE: begin
        wr_addr = pa_idx;
        if (req == REQ_ADD && !eff_pos) begin
          wr_en   = 1'b1;
          wr_data = val;
        end else if (req == REQ_DELETE && eff != '0) begin
          wr_en   = 1'b1;
          wr_data = '0;
        end
      end
      ST_RD_A: rd_addr = xa;
      ST_RD_B: rd_addr = xb;
      ST_WR_X: begin
        // Sort brings its exchange data from the scan; swap and reverse from the RAM
        wr_en   = !(req == REQ_SWAP && swap_zero);
        wr_addr = xa;
        wr_data = (req == REQ_SORT) ? db : eff;
      end
      ST_WR_Y: begin
        wr_en   = 1'b1;
        wr_addr = xb;
        wr_data = da;
      end
      ST_SCAN: rd_addr = scnt;
      default: ;
    endcase
  end

  // Sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      valid    <= '0;
      vld_q    <= 1'b0;
      pipe_vld <= 1'b0;
    end else begin
      state    <= state_next;
      vld_q    <= valid[rd_addr];
      pipe_vld <= (state == ST_SCAN);
      if (wr_en) valid[wr_addr] <= 1'b1;

      pipe_first <= (scnt == sstart);
      pipe_idx   <= scnt;

      case (state)
        ST_IDLE: begin
          // Latch the request and clear fields the request may not produce
          if (start) begin
            req        <= req_type;
            val        <= value;
            pa         <= pos_a;
            pb         <= pos_b;
            res_status <= STAT_OK;
            res_max    <= '0;
            res_min    <= '0;
            res_read   <= '0;
          end
        end
        ST_CHECK: begin
          scnt   <= '0;
          sstart <= '0;
          case (req)
            REQ_ADD, REQ_DELETE, REQ_READ: begin
              if (!a_ok) res_status <= STAT_RANGE;
            end
            REQ_SWAP: begin
              xa <= pa_idx;
              xb <= pb_idx;
              if (!(a_ok && b_ok)) res_status <= STAT_RANGE;
            end
            REQ_REVERSE: begin
              xa <= '0;
              xb <= LAST_IDX;
            end
            default: ;
          endcase
        end
        ST_ONE: begin
          case (req)
            REQ_ADD:    if (eff_pos) res_status <= STAT_OCCUPIED;
            REQ_DELETE: if (eff == '0) res_status <= STAT_ZERO;
            REQ_READ:   res_read <= eff;
            default: ;
          endcase
        end
        ST_RD_B: da <= eff;
        ST_WR_X: begin
          if (req == REQ_SWAP && swap_zero) res_status <= STAT_ZERO_SWAP;
        end
        ST_WR_Y: begin
          // Advance the mirrored pair, or the sort to its next position
          xa     <= xa + AW'(1);
          xb     <= xb - AW'(1);
          sstart <= sstart + AW'(1);
          scnt   <= sstart + AW'(1);
        end
        ST_SCAN: begin
          if (scnt != LAST_IDX) scnt <= scnt + AW'(1);
        end
        ST_FINISH: begin
          // Only minmax reports the extremes; sort leaves them zero
          if (req == REQ_MINMAX) begin
            res_max <= mx;
            res_min <= mn;
          end
          // Sort exchange: position gets the minimum, the minimum's slot gets its old word
          xa <= sstart;
          xb <= sel;
          db <= selval;
          da <= ival;
        end
        default: ;
      endcase

      // Scan compare on the word read the cycle before
      if (pipe_vld) begin
        if (pipe_first) begin
          mx     <= eff;
          mn     <= eff;
          sel    <= pipe_idx;
          selval <= eff;
          ival   <= eff;
        end else begin
          if (eff > mx) mx <= eff;
          if (eff < mn) mn <= eff;
          if (eff < selval) begin
            sel    <= pipe_idx;
            selval <= eff;
          end
        end
      end
    end
  end

  `OAE_ASSERT_ALWAYS(a_rst_idle, rst |=> !busy)
  `OAE_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `OAE_ASSERT(a_done_single, done |=> !done)
  `OAE_ASSERT(a_no_write_idle, !(state == ST_IDLE && wr_en))
  `OAE_ASSERT(a_pipe_from_scan, pipe_vld |-> $past(state) == ST_SCAN)

endmodule
`default_nettype wire
